[src/psal_pkg.sv]
// Package with the transaction types, codes and PLMN decode function of the service area list parser.
`timescale 1ns / 1ps

package psal_pkg;

    // List layout codes from header bits 6..5.
    localparam logic [1:0] LT_PLMN_TACS  = 2'b00;
    localparam logic [1:0] LT_ONE_TAI    = 2'b01;
    localparam logic [1:0] LT_MULTI_TAI  = 2'b10;
    localparam logic [1:0] LT_PLMN_ONLY  = 2'b11;

    // Filler nibble and octet used by the BCD PLMN encoding.
    localparam logic [3:0] FILLER_NIBBLE = 4'hf;
    localparam logic [7:0] FILLER_OCTET  = 8'hff;

    // Parser phases, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PLMN = 3'b010,
        PH_TAC  = 3'b100
    } phase_t;

    // One octet of the encoded list.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       start_req;
    } item_t;

    // One decoded area.
    typedef struct packed {
        logic        allowed_type;
        logic [1:0]  list_type;
        logic [10:0] mcc;
        logic [10:0] mnc;
        logic        mnc_long;
        logic [23:0] tac;
        logic        has_tac;
        logic        last;
    } result_t;

    // Decoded PLMN as held between octet groups.
    typedef struct packed {
        logic [10:0] mcc;
        logic [10:0] mnc;
        logic        mnc_long;
    } plmn_t;

    // Decode three BCD PLMN octets into MCC, MNC and the long-MNC flag.
    function automatic plmn_t decode_plmn(input logic [7:0] o1, input logic [7:0] o2,
                                          input logic [7:0] o3);
        plmn_t       p;
        logic [3:0]  n3;
        logic [10:0] short_mnc;
        n3        = o2[7:4];
        short_mnc = 11'(o3[3:0]) * 11'd10 + 11'(o3[7:4]);
        p.mcc     = 11'(o1[3:0]) * 11'd100 + 11'(o1[7:4]) * 11'd10 + 11'(o2[3:0]);
        if ((n3 != FILLER_NIBBLE) ||
            ((o1 == FILLER_OCTET) && (o2 == FILLER_OCTET) && (o3 == FILLER_OCTET)))
        begin
            p.mnc      = short_mnc * 11'd10 + 11'(n3);
            p.mnc_long = 1'b1;
        end
        else
        begin
            p.mnc      = short_mnc;
            p.mnc_long = 1'b0;
        end
        return p;
    endfunction

endpackage

[src/psal_parser.sv]
// Parser state and per-octet decode step of the service area list parser.
`timescale 1ns / 1ps

module psal_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  psal_pkg::item_t  item,
    output logic             emit,
    output psal_pkg::result_t result
);
    import psal_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  layout_reg, layout_next;
    logic        allowed_reg, allowed_next;
    logic [5:0]  remaining_reg, remaining_next;
    logic [1:0]  octet_index_reg, octet_index_next;
    logic [15:0] plmn_octets_reg, plmn_octets_next;
    plmn_t       held_reg, held_next;
    logic [15:0] tac_partial_reg, tac_partial_next;

    plmn_t       plmn_dec;
    logic [5:0]  remaining_dec;

    assign plmn_dec      = decode_plmn(plmn_octets_reg[15:8], plmn_octets_reg[7:0],
                                       item.byte_in);
    assign remaining_dec = (remaining_reg != 6'd0) ? (remaining_reg - 6'd1) : 6'd0;

    // Next-state and result logic for one octet.
    always_comb
    begin
        phase_next       = phase_reg;
        layout_next      = layout_reg;
        allowed_next     = allowed_reg;
        remaining_next   = remaining_reg;
        octet_index_next = octet_index_reg;
        plmn_octets_next = plmn_octets_reg;
        held_next        = held_reg;
        tac_partial_next = tac_partial_reg;
        emit             = 1'b0;
        result.allowed_type = allowed_reg;
        result.list_type    = layout_reg;
        result.mcc          = held_reg.mcc;
        result.mnc          = held_reg.mnc;
        result.mnc_long     = held_reg.mnc_long;
        result.tac          = {tac_partial_reg, item.byte_in};
        result.has_tac      = 1'b1;
        result.last         = (remaining_dec == 6'd0);

        if (item.start_req)
        begin
            // A header always restarts, dropping any unfinished list.
            allowed_next = item.byte_in[7];
            layout_next  = item.byte_in[6:5];
            if ((item.byte_in[6:5] == LT_PLMN_TACS) || (item.byte_in[6:5] == LT_MULTI_TAI))
            begin
                remaining_next = {1'b0, item.byte_in[4:0]} + 6'd1;
            end
            else
            begin
                remaining_next = 6'd1;
            end
            octet_index_next = 2'd0;
            plmn_octets_next = 16'd0;
            tac_partial_next = 16'd0;
            phase_next       = PH_PLMN;
        end
        else
        begin
            unique case (phase_reg)
                PH_PLMN:
                begin
                    if (octet_index_reg != 2'd2)
                    begin
                        plmn_octets_next = {plmn_octets_reg[7:0], item.byte_in};
                        octet_index_next = octet_index_reg + 2'd1;
                    end
                    else
                    begin
                        held_next        = plmn_dec;
                        octet_index_next = 2'd0;
                        if (layout_reg == LT_PLMN_ONLY)
                        begin
                            // PLMN-only list: the single area is reported at once.
                            remaining_next   = 6'd0;
                            phase_next       = PH_IDLE;
                            emit             = 1'b1;
                            result.mcc       = plmn_dec.mcc;
                            result.mnc       = plmn_dec.mnc;
                            result.mnc_long  = plmn_dec.mnc_long;
                            result.tac       = 24'd0;
                            result.has_tac   = 1'b0;
                            result.last      = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TAC;
                        end
                    end
                end
                PH_TAC:
                begin
                    if (octet_index_reg != 2'd2)
                    begin
                        tac_partial_next = {tac_partial_reg[7:0], item.byte_in};
                        octet_index_next = octet_index_reg + 2'd1;
                    end
                    else
                    begin
                        octet_index_next = 2'd0;
                        tac_partial_next = 16'd0;
                        remaining_next   = remaining_dec;
                        emit             = 1'b1;
                        if (remaining_dec == 6'd0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (layout_reg == LT_MULTI_TAI)
                        begin
                            phase_next = PH_PLMN;
                        end
                        else
                        begin
                            phase_next = PH_TAC;
                        end
                    end
                end
                default:
                begin
                    // Data octets outside a list are ignored.
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // State registers, updated once per processed octet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            layout_reg      <= 2'd0;
            allowed_reg     <= 1'b0;
            remaining_reg   <= 6'd0;
            octet_index_reg <= 2'd0;
            plmn_octets_reg <= 16'd0;
            held_reg        <= '0;
            tac_partial_reg <= 16'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            layout_reg      <= layout_next;
            allowed_reg     <= allowed_next;
            remaining_reg   <= remaining_next;
            octet_index_reg <= octet_index_next;
            plmn_octets_reg <= plmn_octets_next;
            held_reg        <= held_next;
            tac_partial_reg <= tac_partial_next;
        end
    end

endmodule

[src/partial_service_area_list_parser_top.sv]
// Top level of the partial service area list parser: input register, parser and result register.
`timescale 1ns / 1ps

// Byte-serial decoder for a NAS partial service area list. One octet is taken per clock cycle
// on the item channel; an octet with start_req set is a list header and restarts the parser,
// dropping any unfinished list. Each completed area gives one transaction on the result
// channel once its final octet has passed through the input register, where the octet is
// decoded against the parser state, and then through the result register. The
// header and the octets that only fill a PLMN or TAC group give no result. Both registers
// advance together whenever the result register is empty or being read, so the sustained
// rate is one octet per cycle, and a stalled result channel holds off the item channel.

module partial_service_area_list_parser_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  psal_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output psal_pkg::result_t result
);
    import psal_pkg::*;

    logic    stage_valid_reg;
    item_t   stage_reg;
    logic    advance;
    logic    emit;
    result_t result_next;
    logic    result_valid_reg;
    result_t result_reg;

    // The staged octet is processed when the result register can take its outcome.
    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            stage_reg <= item;
        end
    end

    psal_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_reg),
        .emit   (emit),
        .result (result_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= emit;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // An area without a TAC only comes from a PLMN-only list and is always its last area.
    a_no_tac_plmn_only: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.has_tac) |->
        (result.last && (result.list_type == LT_PLMN_ONLY) && (result.tac == 24'd0)))
        else $error("area without TAC outside a PLMN-only list");

    // A single-TAI list holds exactly one area.
    a_one_tai_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.list_type == LT_ONE_TAI)) |-> result.last)
        else $error("single-TAI list gave a non-final area");

    // A staged octet is held while the result channel is stalled.
    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && result_valid_reg && !result_ready) |=>
        (stage_valid_reg && $stable(stage_reg)))
        else $error("staged octet lost under back-pressure");
`endif

endmodule

[test/tb.sv]
// Self-checking testbench for the partial service area list parser.
`timescale 1ns / 1ps

module tb;

    import psal_pkg::*;

    // Decodes the octet stream alongside the block and holds the areas still to arrive.
    class area_scoreboard;

        phase_t      phase         = PH_IDLE;
        logic [1:0]  layout        = 2'b00;
        logic        allowed_bit   = 1'b0;
        logic [5:0]  remaining     = 6'd0;
        logic [2:0]  octet_index   = 3'd0;
        logic [15:0] plmn_octets   = 16'h0000;
        logic [10:0] held_mcc      = 11'd0;
        logic [10:0] held_mnc      = 11'd0;
        logic        held_long     = 1'b0;
        logic [15:0] tac_partial   = 16'h0000;

        result_t     pending_areas[$];
        int          mismatch_count = 0;
        int          areas_by_layout[4] = '{0, 0, 0, 0};

        // BCD decode of one PLMN into the held country and network codes.
        function void decode_network(logic [7:0] o1, logic [7:0] o2, logic [7:0] o3);
            int unsigned two_digit;
            two_digit = 10 * o3[3:0] + o3[7:4];
            held_mcc  = 11'(100 * o1[3:0] + 10 * o1[7:4] + o2[3:0]);
            held_long = (o2[7:4] != FILLER_NIBBLE) || ({o1, o2, o3} == {3{FILLER_OCTET}});
            held_mnc  = held_long ? 11'(two_digit * 10 + o2[7:4]) : 11'(two_digit);
        endfunction

        function void queue_area(logic [23:0] tac, logic has_tac, logic last);
            result_t area;
            area.allowed_type = allowed_bit;
            area.list_type    = layout;
            area.mcc          = held_mcc;
            area.mnc          = held_mnc;
            area.mnc_long     = held_long;
            area.tac          = tac;
            area.has_tac      = has_tac;
            area.last         = last;
            pending_areas = {pending_areas, area};
        endfunction

        // Advances the parser state by one accepted octet.
        function void note_octet(item_t it);
            logic [23:0] tac_full;
            if (it.start_req)
            begin
                allowed_bit = it.byte_in[7];
                layout      = it.byte_in[6:5];
                if (layout == LT_PLMN_TACS || layout == LT_MULTI_TAI)
                    remaining = {1'b0, it.byte_in[4:0]} + 6'd1;
                else
                    remaining = 6'd1;
                octet_index = 3'd0;
                plmn_octets = 16'h0000;
                tac_partial = 16'h0000;
                phase       = PH_PLMN;
            end
            else if (phase == PH_PLMN)
            begin
                if (octet_index < 3'd2)
                begin
                    plmn_octets = {plmn_octets[7:0], it.byte_in};
                    octet_index++;
                end
                else
                begin
                    decode_network(plmn_octets[15:8], plmn_octets[7:0], it.byte_in);
                    octet_index = 3'd0;
                    if (layout == LT_PLMN_ONLY)
                    begin
                        remaining = 6'd0;
                        phase     = PH_IDLE;
                        queue_area(24'h000000, 1'b0, 1'b1);
                    end
                    else
                        phase = PH_TAC;
                end
            end
            else if (phase == PH_TAC)
            begin
                if (octet_index < 3'd2)
                begin
                    tac_partial = {tac_partial[7:0], it.byte_in};
                    octet_index++;
                end
                else
                begin
                    tac_full    = {tac_partial, it.byte_in};
                    octet_index = 3'd0;
                    tac_partial = 16'h0000;
                    if (remaining > 6'd0)
                        remaining--;
                    if (remaining == 6'd0)
                        phase = PH_IDLE;
                    else if (layout == LT_MULTI_TAI)
                        phase = PH_PLMN;
                    else
                        phase = PH_TAC;
                    queue_area(tac_full, 1'b1, remaining == 6'd0);
                end
            end
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        // Compares one result transaction with the oldest expected area.
        function void check_area(result_t got);
            result_t want;
            if (pending_areas.size() == 0)
            begin
                $display("%0t: unexpected area %h, nothing expected", $time, got);
                mismatch_count++;
                return;
            end
            want = pending_areas.pop_front();
            field_check("allowed_type", want.allowed_type, got.allowed_type);
            field_check("list_type", want.list_type, got.list_type);
            field_check("mcc", want.mcc, got.mcc);
            field_check("mnc", want.mnc, got.mnc);
            field_check("mnc_long", want.mnc_long, got.mnc_long);
            field_check("tac", want.tac, got.tac);
            field_check("has_tac", want.has_tac, got.has_tac);
            field_check("last", want.last, got.last);
            areas_by_layout[want.list_type]++;
        endfunction

    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    area_scoreboard board;
    bit             quiet_tail   = 1'b0;
    int             sender_calm  = 0;
    int             octets_sent  = 0;
    int             stray_octets = 0;
    int             lists_sent   = 0;
    int             lists_cut    = 0;

    partial_service_area_list_parser_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Idle length for the next cycle: bursts, calm stretches, and none in the tail.
    function automatic int pick_gap(inout int calm_left);
        if (quiet_tail)
            return 0;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            calm_left = $urandom_range(30, 150);
            return 0;
        end
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(1, 16);
        return 0;
    endfunction

    function automatic logic [7:0] header(logic allowed, logic [1:0] kind, logic [4:0] count_bits);
        return {allowed, kind, count_bits};
    endfunction

    // Three PLMN octets: all filler, arbitrary nibbles, or BCD with two or three MNC digits.
    function automatic logic [23:0] random_plmn();
        logic [3:0] d[6];
        case ($urandom_range(0, 7))
            0: return {3{FILLER_OCTET}};
            1, 2: return 24'($urandom);
            default:
            begin
                foreach (d[i])
                    d[i] = 4'($urandom_range(0, 9));
                if ($urandom_range(0, 1) == 1)
                    d[3] = FILLER_NIBBLE;
                return {d[1], d[0], d[3], d[2], d[5], d[4]};
            end
        endcase
    endfunction

    // Offers one octet and waits for its transaction; valid stays high on return.
    task automatic send_octet(input logic [7:0] b, input logic s);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid = 1'b0;
            item.byte_in   = 8'($urandom);
            item.start_req = 1'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid     = 1'b1;
        item.byte_in   = b;
        item.start_req = s;
        do
            @(posedge clk);
        while (!item_ready);
        board.note_octet(item);
        octets_sent++;
    endtask

    task automatic send_list(input logic [7:0] octets[$]);
        foreach (octets[i])
            send_octet(octets[i], i == 0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (board.pending_areas.size() != 0)
            @(posedge clk);
    endtask

    // A random list, mostly well formed and short, sometimes cut off by the next header.
    task automatic send_random_list();
        logic [7:0]  octs[$];
        logic [7:0]  hdr;
        logic [23:0] field;
        int          areas;
        int          keep;
        bit          cut;
        hdr = 8'($urandom);
        case ($urandom_range(0, 11))
            0: hdr[4:0] = 5'h1f;
            1: ;
            default: hdr[4:0] = 5'($urandom_range(0, 3));
        endcase
        areas = (hdr[6:5] == LT_PLMN_TACS || hdr[6:5] == LT_MULTI_TAI) ? hdr[4:0] + 1 : 1;
        octs = {octs, hdr};
        for (int i = -1; i < areas; i++)
        begin
            if ((i < 0) ? (hdr[6:5] != LT_MULTI_TAI) : (hdr[6:5] == LT_MULTI_TAI))
            begin
                field = random_plmn();
                octs = {octs, field[23:16], field[15:8], field[7:0]};
            end
            if (i >= 0 && hdr[6:5] != LT_PLMN_ONLY)
            begin
                if ($urandom_range(0, 9) == 0)
                    field = ($urandom_range(0, 1) == 1) ? 24'hffffff : 24'h000000;
                else
                    field = 24'($urandom);
                octs = {octs, field[23:16], field[15:8], field[7:0]};
            end
        end
        cut = ($urandom_range(0, 7) == 0);
        if (cut)
        begin
            keep = $urandom_range(1, octs.size() - 1);
            octs = octs[0:keep - 1];
            lists_cut++;
        end
        send_list(octs);
        lists_sent++;
        // Stray octets after a finished list are ignored by the parser.
        if (!cut && $urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                send_octet(8'($urandom), 1'b0);
                stray_octets++;
            end
        end
    endtask

    // Result channel: random stalls, then ready held high.
    initial
    begin
        int stall;
        int calm;
        calm = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = pick_gap(calm);
            if (stall > 0)
            begin
                result_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready = 1'b1;
        end
    end

    // Every result transaction is checked against the oldest expected area.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_area(result);
    end

    // Stimulus: directed lists first, then random lists.
    initial
    begin
        logic [7:0] octs[$];
        board      = new();
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Data octets while idle are ignored.
        send_octet(8'h00, 1'b0);
        send_octet(8'hff, 1'b0);
        stray_octets += 2;

        // PLMN-only list with count bits set, all-filler PLMN.
        octs = {header(1'b1, LT_PLMN_ONLY, 5'h1f), 8'hff, 8'hff, 8'hff};
        send_list(octs);

        // Single TAI with ignored count bits, short MNC, zero TAC.
        octs = {header(1'b0, LT_ONE_TAI, 5'h1f), 8'h21, 8'hf3, 8'h54, 8'h00, 8'h00, 8'h00};
        send_list(octs);

        // One PLMN with two TACs, abandoned by a new header part way through the second.
        octs = {header(1'b0, LT_PLMN_TACS, 5'h01), 8'h00, 8'h00, 8'h00,
                8'hff, 8'hff, 8'hff, 8'h12};
        send_list(octs);

        // Several TAIs holding one area, with non-decimal nibbles.
        octs = {header(1'b1, LT_MULTI_TAI, 5'h00), 8'hab, 8'hcd, 8'hef,
                8'h12, 8'h34, 8'h56};
        send_list(octs);

        while (octets_sent - stray_octets < 550)
        begin
            quiet_tail = (octets_sent - stray_octets > 470);
            if (lists_sent == 20 || (!quiet_tail && $urandom_range(0, 39) == 0))
                wait_drained();
            send_random_list();
        end

        wait_drained();
        repeat (4) @(posedge clk);
        $display("Sent %0d octets (%0d ignored) in %0d random lists, %0d of them cut short.",
                 octets_sent, stray_octets, lists_sent, lists_cut);
        $display("Areas checked per layout 00/01/10/11: %0d/%0d/%0d/%0d.",
                 board.areas_by_layout[0], board.areas_by_layout[1],
                 board.areas_by_layout[2], board.areas_by_layout[3]);
        if (board.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Timeout with %0d areas outstanding", board.pending_areas.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
src/psal_pkg.sv
src/psal_parser.sv
src/partial_service_area_list_parser_top.sv
test/tb.sv
